FILE: design/sslc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sslc_pkg
// shared types, codes and helpers of the session status light controller
// ----------------------------------------------------------------------------
package sslc_pkg;

  localparam int TABLE_ENTRIES_DEF = 8;

  // request types
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_EVENT = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // signal codes
  localparam logic [3:0] SIG_THINKING   = 4'd1;
  localparam logic [3:0] SIG_TOOL_DONE  = 4'd3;
  localparam logic [3:0] SIG_ATTENTION  = 4'd4;
  localparam logic [3:0] SIG_PERMISSION = 4'd5;
  localparam logic [3:0] SIG_BLOCKED    = 4'd6;
  localparam logic [3:0] SIG_DONE       = 4'd7;
  localparam logic [3:0] SIG_SESS_END   = 4'd9;
  localparam logic [3:0] SIG_SESS_DONE  = 4'd10;
  localparam logic [3:0] SIG_OFF        = 4'd11;
  localparam logic [3:0] SIG_TURN_END   = 4'd12;

  // lamp patterns
  localparam logic [2:0] PAT_OFF    = 3'd0;
  localparam logic [2:0] PAT_GREEN  = 3'd1;
  localparam logic [2:0] PAT_WORK   = 3'd2;
  localparam logic [2:0] PAT_FYEL   = 3'd3;
  localparam logic [2:0] PAT_FRED   = 3'd4;
  localparam logic [2:0] PAT_NOTICE = 3'd5;

  // aggregate levels
  localparam logic [2:0] LVL_IDLE       = 3'd0;
  localparam logic [2:0] LVL_WORKING    = 3'd1;
  localparam logic [2:0] LVL_ATTENTION  = 3'd2;
  localparam logic [2:0] LVL_PERMISSION = 3'd3;
  localparam logic [2:0] LVL_BLOCKED    = 3'd4;

  // lamp bits: red, yellow, green
  localparam logic [2:0] LAMP_NONE = 3'b000;
  localparam logic [2:0] LAMP_G    = 3'b001;
  localparam logic [2:0] LAMP_Y    = 3'b010;
  localparam logic [2:0] LAMP_R    = 3'b100;

  // configuration register indexes
  localparam logic [2:0] REG_FLASH_ON   = 3'd0;
  localparam logic [2:0] REG_FLASH_OFF  = 3'd1;
  localparam logic [2:0] REG_NOTICE_ON  = 3'd2;
  localparam logic [2:0] REG_NOTICE_OFF = 3'd3;
  localparam logic [2:0] REG_NOTICE_REP = 3'd4;
  localparam logic [2:0] REG_WORK_STEP  = 3'd5;
  localparam logic [2:0] REG_LIFETIME   = 3'd6;
  localparam logic [2:0] REG_IDLE_SLEEP = 3'd7;

  localparam logic [15:0] FLASH_ON_RST   = 16'd500;
  localparam logic [15:0] FLASH_OFF_RST  = 16'd500;
  localparam logic [15:0] NOTICE_ON_RST  = 16'd200;
  localparam logic [15:0] NOTICE_OFF_RST = 16'd200;
  localparam logic [7:0]  NOTICE_REP_RST = 8'd3;
  localparam logic [15:0] WORK_STEP_RST  = 16'd600;
  localparam logic [15:0] LIFETIME_RST   = 16'd600;
  localparam logic [31:0] IDLE_SLEEP_RST = 32'd300000;

  localparam logic [31:0] PRUNE_INTERVAL_MS = 32'd10000;
  localparam int          TTL_W             = 26;
  localparam logic [TTL_W-1:0] MS_PER_SECOND = TTL_W'(1000);

  typedef struct packed {
    logic [31:0] key;
    logic [3:0]  sig;
    logic [31:0] stamp;
  } entry_t;

  function automatic logic [2:0] level_pattern(input logic [2:0] lvl);
    logic [2:0] p;
    case (lvl)
      LVL_WORKING:    p = PAT_WORK;
      LVL_ATTENTION:  p = PAT_FYEL;
      LVL_PERMISSION: p = PAT_FYEL;
      LVL_BLOCKED:    p = PAT_FRED;
      default:        p = PAT_GREEN;
    endcase
    return p;
  endfunction

  function automatic logic [2:0] sig_level(input logic [3:0] s);
    logic [2:0] l;
    if (s == SIG_BLOCKED) l = LVL_BLOCKED;
    else if (s == SIG_PERMISSION) l = LVL_PERMISSION;
    else if (s == SIG_ATTENTION || s == SIG_DONE) l = LVL_ATTENTION;
    else if (s >= SIG_THINKING && s <= SIG_TOOL_DONE) l = LVL_WORKING;
    else l = LVL_IDLE;
    return l;
  endfunction

endpackage

FILE: design/sslc_table_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sslc_table_ram
// session table memory, one write and one registered read port
// ----------------------------------------------------------------------------
module sslc_table_ram
  import sslc_pkg::*;
#(
  parameter int DEPTH = TABLE_ENTRIES_DEF,
  parameter int AW    = 3
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/session_status_light_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// session_status_light_controller_unit
// session table with priority aggregate and three-lamp pattern generator
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o  | req_type, session_key, signal_code
//  out     | output    | out_valid_o / out_stall_i| lamps, pattern, status, count
//  cfg     | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
//  one item at a time; a tick runs the animation step and the sleep check, plus
//  a check of each entry when a prune pass runs, and a rescan of the table and
//  the level update when that pass drops entries
//  an event with a known code takes a lookup scan and a level scan through the
//  single read port of the table memory
//  reset clears control state; table contents are only read below the count
//  a result waits in the output register while the next item is taken in
// ----------------------------------------------------------------------------
module session_status_light_controller_unit
  import sslc_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] session_key_i,
  input  logic [3:0]  signal_code_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        red_lamp_o,
  output logic        yellow_lamp_o,
  output logic        green_lamp_o,
  output logic [2:0]  shown_pattern_o,
  output logic [2:0]  combined_status_o,
  output logic        event_status_o,
  output logic [3:0]  live_sessions_o,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  // sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SCAN   = 4'd1;
  localparam logic [3:0] ST_EVACT  = 4'd2;
  localparam logic [3:0] ST_DROPWR = 4'd3;
  localparam logic [3:0] ST_APPLY  = 4'd4;
  localparam logic [3:0] ST_ANIM   = 4'd5;
  localparam logic [3:0] ST_SLEEP  = 4'd6;
  localparam logic [3:0] ST_PRD    = 4'd7;
  localparam logic [3:0] ST_PCHK   = 4'd8;
  localparam logic [3:0] ST_PMV    = 4'd9;
  localparam logic [3:0] ST_OUT    = 4'd10;

  // configuration registers
  logic [15:0] flash_on_q, flash_off_q, notice_on_q, notice_off_q;
  logic [15:0] work_step_q, lifetime_q;
  logic [7:0]  notice_rep_q;
  logic [31:0] idle_sleep_q;

  // control state
  logic [3:0]  st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [31:0] now_q, now_d;
  logic [2:0]  agg_q, agg_d;
  logic [2:0]  pat_q, pat_d;
  logic [1:0]  anim_q, anim_d;
  logic [7:0]  loops_q, loops_d;
  logic [31:0] step_q, step_d;
  logic [31:0] idle_stamp_q, idle_stamp_d;
  logic        armed_q, armed_d;
  logic [31:0] prune_q, prune_d;
  logic [2:0]  lamp_q, lamp_d;

  // item and scan working registers
  logic [1:0]  req_q, req_d;
  logic [31:0] key_q, key_d;
  logic [3:0]  code_q, code_d;
  logic        status_q, status_d;
  logic        notice_q, notice_d;
  logic        mode_rec_q, mode_rec_d;   // scan purpose: level rescan or lookup
  logic [CW-1:0] sidx_q, sidx_d;
  logic        pend_q, pend_d;
  logic [CW-1:0] pidx_q, pidx_d;
  logic        found_q, found_d;
  logic [IW-1:0] at_q, at_d;
  logic [3:0]  at_sig_q, at_sig_d;
  logic [31:0] min_q, min_d;
  logic [IW-1:0] minidx_q, minidx_d;
  logic [2:0]  lvl_q, lvl_d;
  logic [CW-1:0] pi_q, pi_d;
  logic [CW-1:0] before_q, before_d;
  logic [TTL_W-1:0] ttl_q, ttl_d;

  // output register
  logic        ovalid_q, ovalid_d;
  logic [2:0]  olamp_q;
  logic [2:0]  opat_q, oagg_q;
  logic        ostat_q;
  logic [CW-1:0] ocnt_q;
  logic        oload;

  // table memory port
  logic        we, re;
  logic [IW-1:0] waddr, raddr;
  entry_t      wdata, rdata;

  sslc_table_ram #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (IW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic [31:0] gone;
  logic [CW-1:0] cnt_m1;
  logic          issue;
  logic [1:0]    phase;
  logic          on_ph;
  logic [15:0]   thr;
  logic [7:0]    loops_n;
  logic [2:0]    pn;

  assign gone   = now_q - step_q;
  assign cnt_m1 = cnt_q - CW'(1);
  assign issue  = (sidx_q < cnt_q);

  always_comb begin
    st_d = st_q;
    cnt_d = cnt_q;
    now_d = now_q;
    agg_d = agg_q;
    pat_d = pat_q;
    anim_d = anim_q;
    loops_d = loops_q;
    step_d = step_q;
    idle_stamp_d = idle_stamp_q;
    armed_d = armed_q;
    prune_d = prune_q;
    lamp_d = lamp_q;
    req_d = req_q;
    key_d = key_q;
    code_d = code_q;
    status_d = status_q;
    notice_d = notice_q;
    mode_rec_d = mode_rec_q;
    sidx_d = sidx_q;
    pend_d = pend_q;
    pidx_d = pidx_q;
    found_d = found_q;
    at_d = at_q;
    at_sig_d = at_sig_q;
    min_d = min_q;
    minidx_d = minidx_q;
    lvl_d = lvl_q;
    pi_d = pi_q;
    before_d = before_q;
    ttl_d = ttl_q;
    we = 1'b0;
    re = 1'b0;
    waddr = '0;
    raddr = '0;
    wdata = rdata;
    oload = 1'b0;
    phase = '0;
    on_ph = 1'b0;
    thr = '0;
    loops_n = '0;
    pn = PAT_OFF;

    case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d = req_type_i;
          key_d = session_key_i;
          code_d = signal_code_i;
          notice_d = 1'b0;
          status_d = 1'b0;
          case (req_type_i)
            REQ_TICK: begin
              now_d = now_q + 32'd1;
              st_d = ST_ANIM;
            end
            REQ_EVENT: begin
              if (signal_code_i > SIG_TURN_END) begin
                status_d = 1'b1;
                st_d = ST_OUT;
              end else begin
                // lookup scan, also finds the oldest entry
                mode_rec_d = 1'b0;
                sidx_d = '0;
                pend_d = 1'b0;
                found_d = 1'b0;
                st_d = ST_SCAN;
              end
            end
            REQ_CLEAR: begin
              cnt_d = '0;
              agg_d = LVL_IDLE;
              pat_d = PAT_OFF;
              lamp_d = LAMP_NONE;
              armed_d = 1'b0;
              st_d = ST_OUT;
            end
            default: st_d = ST_OUT;
          endcase
        end
      end

      ST_SCAN: begin
        // one read issued per cycle, its data handled in the cycle after
        re = issue;
        raddr = sidx_q[IW-1:0];
        if (issue) sidx_d = sidx_q + CW'(1);
        pend_d = issue;
        pidx_d = sidx_q;
        if (pend_q) begin
          if (mode_rec_q) begin
            if (sig_level(rdata.sig) > lvl_q) lvl_d = sig_level(rdata.sig);
          end else begin
            if (rdata.key == key_q && !found_q) begin
              found_d = 1'b1;
              at_d = pidx_q[IW-1:0];
              at_sig_d = rdata.sig;
            end
            if (pidx_q == '0 || rdata.stamp < min_q) begin
              min_d = rdata.stamp;
              minidx_d = pidx_q[IW-1:0];
            end
          end
        end
        if (!issue && !pend_q) begin
          st_d = mode_rec_q ? ST_APPLY : ST_EVACT;
        end
      end

      ST_EVACT: begin
        // default next: level rescan
        mode_rec_d = 1'b1;
        sidx_d = '0;
        pend_d = 1'b0;
        lvl_d = LVL_IDLE;
        st_d = ST_SCAN;
        if (code_q == SIG_SESS_END || code_q == SIG_SESS_DONE || code_q == SIG_OFF) begin
          if (found_q) begin
            re = 1'b1;
            raddr = cnt_m1[IW-1:0];
            cnt_d = cnt_m1;
            notice_d = (code_q != SIG_OFF);
            st_d = ST_DROPWR;
          end
        end else if (code_q == SIG_TURN_END) begin
          if (found_q && at_sig_q != SIG_PERMISSION && at_sig_q != SIG_BLOCKED) begin
            re = 1'b1;
            raddr = cnt_m1[IW-1:0];
            cnt_d = cnt_m1;
            notice_d = 1'b1;
            st_d = ST_DROPWR;
          end
        end else begin
          we = 1'b1;
          wdata.key = key_q;
          wdata.sig = code_q;
          wdata.stamp = now_q;
          if (found_q) begin
            waddr = at_q;
          end else if (cnt_q >= CW'(TABLE_ENTRIES)) begin
            waddr = minidx_q;  // full table: evict the oldest
          end else begin
            waddr = cnt_q[IW-1:0];
            cnt_d = cnt_q + CW'(1);
          end
        end
      end

      ST_DROPWR: begin
        // last entry moves into the freed slot
        we = 1'b1;
        waddr = at_q;
        wdata = rdata;
        st_d = ST_SCAN;
      end

      ST_APPLY: begin
        if (lvl_q != agg_q) begin
          agg_d = lvl_q;
          pn = level_pattern(lvl_q);
          if (pn != pat_q) begin
            pat_d = pn;
            anim_d = '0;
            loops_d = '0;
            step_d = now_q;
            if (pn == PAT_GREEN) lamp_d = LAMP_G;
          end
        end
        if (lvl_q == LVL_IDLE) begin
          if (!armed_q) begin
            armed_d = 1'b1;
            idle_stamp_d = now_q;
          end
        end else begin
          armed_d = 1'b0;
        end
        if (notice_q && lvl_q != LVL_BLOCKED && lvl_q != LVL_PERMISSION &&
            lvl_q != LVL_ATTENTION) begin
          pat_d = PAT_NOTICE;
          anim_d = '0;
          loops_d = '0;
          step_d = now_q;
        end
        st_d = ST_OUT;
      end

      ST_ANIM: begin
        st_d = ST_SLEEP;
        case (pat_q)
          PAT_WORK: begin
            if (gone >= 32'(work_step_q)) begin
              step_d = now_q;
              phase = (anim_q == 2'd3) ? 2'd0 : anim_q;
              case (phase)
                2'd0:    lamp_d = LAMP_G;
                2'd1:    lamp_d = LAMP_Y;
                default: lamp_d = LAMP_R;
              endcase
              if (phase == 2'd2) begin
                anim_d = '0;
                loops_d = loops_q + 8'd1;
              end else begin
                anim_d = phase + 2'd1;
              end
            end
          end
          PAT_FYEL, PAT_FRED: begin
            on_ph = !anim_q[0];
            thr = on_ph ? flash_on_q : flash_off_q;
            if (gone >= 32'(thr)) begin
              step_d = now_q;
              lamp_d = on_ph ? ((pat_q == PAT_FYEL) ? LAMP_Y : LAMP_R) : LAMP_NONE;
              if (on_ph) begin
                anim_d = 2'd1;
              end else begin
                anim_d = '0;
                loops_d = loops_q + 8'd1;
              end
            end
          end
          PAT_NOTICE: begin
            on_ph = !anim_q[0];
            thr = on_ph ? notice_on_q : notice_off_q;
            if (gone >= 32'(thr)) begin
              step_d = now_q;
              lamp_d = on_ph ? LAMP_G : LAMP_NONE;
              if (on_ph) begin
                anim_d = 2'd1;
              end else begin
                anim_d = '0;
                loops_n = loops_q + 8'd1;
                loops_d = loops_n;
                if (loops_n >= notice_rep_q) begin
                  // notice done: back to the pattern of the aggregate
                  pn = level_pattern(agg_q);
                  pat_d = pn;
                  loops_d = '0;
                  if (pn == PAT_GREEN) lamp_d = LAMP_G;
                end
              end
            end
          end
          default: ;
        endcase
      end

      ST_SLEEP: begin
        ttl_d = TTL_W'(lifetime_q) * MS_PER_SECOND;
        if (armed_q && pat_q == PAT_GREEN && (now_q - idle_stamp_q) > idle_sleep_q) begin
          pat_d = PAT_OFF;
          lamp_d = LAMP_NONE;
          armed_d = 1'b0;
        end
        if ((now_q - prune_q) > PRUNE_INTERVAL_MS) begin
          prune_d = now_q;
          before_d = cnt_q;
          pi_d = '0;
          st_d = ST_PRD;
        end else begin
          st_d = ST_OUT;
        end
      end

      ST_PRD: begin
        if (pi_q < cnt_q) begin
          re = 1'b1;
          raddr = pi_q[IW-1:0];
          st_d = ST_PCHK;
        end else if (cnt_q != before_q) begin
          mode_rec_d = 1'b1;
          sidx_d = '0;
          pend_d = 1'b0;
          lvl_d = LVL_IDLE;
          st_d = ST_SCAN;
        end else begin
          st_d = ST_OUT;
        end
      end

      ST_PCHK: begin
        if ((now_q - rdata.stamp) > 32'(ttl_q)) begin
          re = 1'b1;
          raddr = cnt_m1[IW-1:0];
          cnt_d = cnt_m1;
          st_d = ST_PMV;
        end else begin
          pi_d = pi_q + CW'(1);
          st_d = ST_PRD;
        end
      end

      ST_PMV: begin
        // same slot is checked again after the move
        we = 1'b1;
        waddr = pi_q[IW-1:0];
        wdata = rdata;
        st_d = ST_PRD;
      end

      ST_OUT: begin
        if (!ovalid_q || !out_stall_i) begin
          oload = 1'b1;
          st_d = ST_IDLE;
        end
      end

      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q && out_stall_i;
    if (oload) ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_on_q <= FLASH_ON_RST;
      flash_off_q <= FLASH_OFF_RST;
      notice_on_q <= NOTICE_ON_RST;
      notice_off_q <= NOTICE_OFF_RST;
      notice_rep_q <= NOTICE_REP_RST;
      work_step_q <= WORK_STEP_RST;
      lifetime_q <= LIFETIME_RST;
      idle_sleep_q <= IDLE_SLEEP_RST;
      st_q <= ST_IDLE;
      cnt_q <= '0;
      now_q <= '0;
      agg_q <= LVL_IDLE;
      pat_q <= PAT_GREEN;
      anim_q <= '0;
      loops_q <= '0;
      step_q <= '0;
      idle_stamp_q <= '0;
      armed_q <= 1'b1;
      prune_q <= '0;
      lamp_q <= LAMP_G;
      mode_rec_q <= 1'b0;
      sidx_q <= '0;
      pend_q <= 1'b0;
      found_q <= 1'b0;
      notice_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_FLASH_ON:   flash_on_q <= cfg_data_i[15:0];
          REG_FLASH_OFF:  flash_off_q <= cfg_data_i[15:0];
          REG_NOTICE_ON:  notice_on_q <= cfg_data_i[15:0];
          REG_NOTICE_OFF: notice_off_q <= cfg_data_i[15:0];
          REG_NOTICE_REP: notice_rep_q <= cfg_data_i[7:0];
          REG_WORK_STEP:  work_step_q <= cfg_data_i[15:0];
          REG_LIFETIME:   lifetime_q <= cfg_data_i[15:0];
          REG_IDLE_SLEEP: idle_sleep_q <= cfg_data_i;
          default: ;
        endcase
      end
      st_q <= st_d;
      cnt_q <= cnt_d;
      now_q <= now_d;
      agg_q <= agg_d;
      pat_q <= pat_d;
      anim_q <= anim_d;
      loops_q <= loops_d;
      step_q <= step_d;
      idle_stamp_q <= idle_stamp_d;
      armed_q <= armed_d;
      prune_q <= prune_d;
      lamp_q <= lamp_d;
      mode_rec_q <= mode_rec_d;
      sidx_q <= sidx_d;
      pend_q <= pend_d;
      found_q <= found_d;
      notice_q <= notice_d;
      ovalid_q <= ovalid_d;
    end
  end

  // payload, scan working and output registers, no reset needed
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    key_q <= key_d;
    code_q <= code_d;
    status_q <= status_d;
    pidx_q <= pidx_d;
    at_q <= at_d;
    at_sig_q <= at_sig_d;
    min_q <= min_d;
    minidx_q <= minidx_d;
    lvl_q <= lvl_d;
    pi_q <= pi_d;
    before_q <= before_d;
    ttl_q <= ttl_d;
    if (oload) begin
      olamp_q <= lamp_q;
      opat_q <= pat_q;
      oagg_q <= agg_q;
      ostat_q <= status_q;
      ocnt_q <= cnt_q;
    end
  end

  assign in_stall_o        = (st_q != ST_IDLE);
  assign out_valid_o       = ovalid_q;
  assign red_lamp_o        = olamp_q[2];
  assign yellow_lamp_o     = olamp_q[1];
  assign green_lamp_o      = olamp_q[0];
  assign shown_pattern_o   = opat_q;
  assign combined_status_o = oagg_q;
  assign event_status_o    = ostat_q;
  assign live_sessions_o   = 4'(ocnt_q);

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the session status light controller: a lamp and
// session-table predictor runs beside the unit, every result item is compared
// field by field, under random idling, back-pressure and register settings
// ----------------------------------------------------------------------------
module tb;
  import sslc_pkg::*;

  localparam int NSLOT     = TABLE_ENTRIES_DEF;
  localparam int WDOG_MAX  = 20000;
  localparam int HOLD_LEN  = 600;
  localparam int SETTLE    = 60;
  localparam logic [1:0] REQ_RSVD = 2'd3;

  typedef struct packed {
    logic       red;
    logic       yel;
    logic       grn;
    logic [2:0] pat;
    logic [2:0] lvl;
    logic       evt;
    logic [3:0] cnt;
  } lamp_view_t;

  // dut signals, every driven input known from time zero
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = REQ_TICK;
  logic [31:0] sess_key = '0;
  logic [3:0]  sig_code = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        red_o, yel_o, grn_o, evt_o;
  logic [2:0]  pat_o, lvl_o;
  logic [3:0]  cnt_o;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = REG_FLASH_ON;
  logic [31:0] cfg_data = '0;

  session_status_light_controller_unit uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .req_type_i(req_type), .session_key_i(sess_key), .signal_code_i(sig_code),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .red_lamp_o(red_o), .yellow_lamp_o(yel_o), .green_lamp_o(grn_o),
    .shown_pattern_o(pat_o), .combined_status_o(lvl_o),
    .event_status_o(evt_o), .live_sessions_o(cnt_o),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // expected result items, oldest first
  lamp_view_t lamp_expect_q[$];
  int         err_cnt = 0;
  bit         idling_on = 1'b1;
  bit         hold_req = 1'b0;
  int         quiet_cycles = 0;

  // ---------------------------------------------------------------------
  // predictor state: register copies and the session table
  // ---------------------------------------------------------------------
  logic [31:0] r_flash_on, r_flash_off, r_notice_on, r_notice_off;
  logic [31:0] r_notice_rep, r_work_step, r_lifetime, r_idle_sleep;
  logic [31:0] s_key   [NSLOT];
  logic [3:0]  s_sig   [NSLOT];
  logic [31:0] s_stamp [NSLOT];
  int          s_count;
  logic [31:0] now_ms, step_t, idle_t, prune_t;
  logic [2:0]  level, pattern, lamps;
  int          anim_ph;
  logic [7:0]  anim_rounds;
  bit          sleep_armed;

  function automatic logic [2:0] pattern_for(logic [2:0] lv);
    case (lv)
      LVL_WORKING:                   return PAT_WORK;
      LVL_ATTENTION, LVL_PERMISSION: return PAT_FYEL;
      LVL_BLOCKED:                   return PAT_FRED;
      default:                       return PAT_GREEN;
    endcase
  endfunction

  function int slot_of_key(logic [31:0] k);
    for (int i = 0; i < s_count; i++) begin
      if (s_key[i] == k) return i;
    end
    return -1;
  endfunction

  // removal moves the last entry into the hole
  function void drop_session(int i);
    s_count--;
    s_key[i]   = s_key[s_count];
    s_sig[i]   = s_sig[s_count];
    s_stamp[i] = s_stamp[s_count];
  endfunction

  function void put_session(logic [31:0] k, logic [3:0] c);
    int at;
    at = slot_of_key(k);
    if (at < 0) begin
      if (s_count >= NSLOT) begin
        // oldest stamp goes, first one on ties
        at = 0;
        for (int i = 1; i < NSLOT; i++) begin
          if (s_stamp[i] < s_stamp[at]) at = i;
        end
      end else begin
        at = s_count++;
      end
      s_key[at] = k;
    end
    s_sig[at]   = c;
    s_stamp[at] = now_ms;
  endfunction

  function void restart_anim();
    anim_ph     = 0;
    anim_rounds = '0;
    step_t      = now_ms;
  endfunction

  function void rescan_level();
    logic [2:0] lv;
    logic [2:0] p;
    lv = LVL_IDLE;
    for (int i = 0; i < s_count; i++) begin
      if (s_sig[i] == SIG_BLOCKED) lv = LVL_BLOCKED;
      else if (s_sig[i] == SIG_PERMISSION) begin
        if (lv < LVL_PERMISSION) lv = LVL_PERMISSION;
      end else if (s_sig[i] == SIG_ATTENTION || s_sig[i] == SIG_DONE) begin
        if (lv < LVL_ATTENTION) lv = LVL_ATTENTION;
      end else if (s_sig[i] >= SIG_THINKING && s_sig[i] <= SIG_TOOL_DONE) begin
        if (lv < LVL_WORKING) lv = LVL_WORKING;
      end
    end
    if (lv != level) begin
      level = lv;
      p = pattern_for(lv);
      if (p != pattern) begin
        pattern = p;
        restart_anim();
        if (p == PAT_GREEN) lamps = LAMP_G;
      end
    end
    if (lv == LVL_IDLE) begin
      if (!sleep_armed) begin
        sleep_armed = 1'b1;
        idle_t = now_ms;
      end
    end else begin
      sleep_armed = 1'b0;
    end
  endfunction

  function void apply_event(logic [31:0] k, logic [3:0] c);
    bit notice;
    int at;
    notice = 1'b0;
    if (c == SIG_SESS_END || c == SIG_SESS_DONE || c == SIG_OFF) begin
      at = slot_of_key(k);
      if (at >= 0) begin
        drop_session(at);
        notice = (c != SIG_OFF);
      end
    end else if (c == SIG_TURN_END) begin
      at = slot_of_key(k);
      if (at >= 0 && s_sig[at] != SIG_PERMISSION && s_sig[at] != SIG_BLOCKED) begin
        notice = 1'b1;
        drop_session(at);
      end
    end else begin
      put_session(k, c);
    end
    rescan_level();
    if (notice && level != LVL_BLOCKED && level != LVL_PERMISSION &&
        level != LVL_ATTENTION) begin
      pattern = PAT_NOTICE;
      restart_anim();
    end
  endfunction

  function void advance_anim();
    logic [31:0] gone;
    bit lit;
    gone = now_ms - step_t;
    if (pattern == PAT_WORK) begin
      if (gone < r_work_step) return;
      step_t = now_ms;
      anim_ph = anim_ph % 3;
      lamps = (anim_ph == 0) ? LAMP_G : ((anim_ph == 1) ? LAMP_Y : LAMP_R);
      anim_ph++;
      if (anim_ph >= 3) begin
        anim_ph = 0;
        anim_rounds++;
      end
    end else if (pattern == PAT_FYEL || pattern == PAT_FRED) begin
      lit = (anim_ph % 2) == 0;
      if (gone < (lit ? r_flash_on : r_flash_off)) return;
      step_t = now_ms;
      lamps = lit ? ((pattern == PAT_FYEL) ? LAMP_Y : LAMP_R) : LAMP_NONE;
      anim_ph = (anim_ph % 2) + 1;
      if (anim_ph >= 2) begin
        anim_ph = 0;
        anim_rounds++;
      end
    end else if (pattern == PAT_NOTICE) begin
      lit = (anim_ph % 2) == 0;
      if (gone < (lit ? r_notice_on : r_notice_off)) return;
      step_t = now_ms;
      lamps = lit ? LAMP_G : LAMP_NONE;
      anim_ph = (anim_ph % 2) + 1;
      if (anim_ph >= 2) begin
        anim_ph = 0;
        anim_rounds++;
        // notice done: fall back to the pattern of the aggregate
        if ({24'd0, anim_rounds} >= r_notice_rep) begin
          pattern = pattern_for(level);
          restart_anim();
          if (pattern == PAT_GREEN) lamps = LAMP_G;
        end
      end
    end
  endfunction

  function void apply_tick();
    logic [31:0] ttl;
    int count_was, i;
    now_ms++;
    advance_anim();
    if (sleep_armed && pattern == PAT_GREEN && now_ms - idle_t > r_idle_sleep) begin
      pattern = PAT_OFF;
      lamps = LAMP_NONE;
      sleep_armed = 1'b0;
    end
    if (now_ms - prune_t > PRUNE_INTERVAL_MS) begin
      prune_t = now_ms;
      ttl = r_lifetime * 32'd1000;
      count_was = s_count;
      i = 0;
      while (i < s_count) begin
        if (now_ms - s_stamp[i] > ttl) drop_session(i);
        else i++;
      end
      if (s_count != count_was) rescan_level();
    end
  endfunction

  function lamp_view_t predict_lamps(logic [1:0] rq, logic [31:0] k, logic [3:0] c);
    lamp_view_t v;
    v.evt = 1'b0;
    case (rq)
      REQ_TICK: apply_tick();
      REQ_EVENT: begin
        if (c > SIG_TURN_END) v.evt = 1'b1;
        else apply_event(k, c);
      end
      REQ_CLEAR: begin
        s_count = 0;
        level = LVL_IDLE;
        pattern = PAT_OFF;
        lamps = LAMP_NONE;
        sleep_armed = 1'b0;
      end
      default: ;
    endcase
    v.red = lamps[2];
    v.yel = lamps[1];
    v.grn = lamps[0];
    v.pat = pattern;
    v.lvl = level;
    v.cnt = 4'(s_count);
    return v;
  endfunction

  function void predictor_reset();
    r_flash_on = FLASH_ON_RST;    r_flash_off = FLASH_OFF_RST;
    r_notice_on = NOTICE_ON_RST;  r_notice_off = NOTICE_OFF_RST;
    r_notice_rep = NOTICE_REP_RST; r_work_step = WORK_STEP_RST;
    r_lifetime = LIFETIME_RST;    r_idle_sleep = IDLE_SLEEP_RST;
    s_count = 0;
    now_ms = '0; step_t = '0; idle_t = '0; prune_t = '0;
    level = LVL_IDLE;
    pattern = PAT_GREEN;
    lamps = LAMP_G;
    anim_ph = 0;
    anim_rounds = '0;
    sleep_armed = 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------
  task automatic send_item(logic [1:0] rq, logic [31:0] k, logic [3:0] c);
    if (idling_on && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq;
    sess_key <= k;
    sig_code <= c;
    do @(posedge clk); while (in_stall);
    lamp_expect_q.push_back(predict_lamps(rq, k, c));
  endtask

  // sender pauses until every result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (lamp_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    case (idx)
      REG_FLASH_ON:   r_flash_on   = {16'd0, val[15:0]};
      REG_FLASH_OFF:  r_flash_off  = {16'd0, val[15:0]};
      REG_NOTICE_ON:  r_notice_on  = {16'd0, val[15:0]};
      REG_NOTICE_OFF: r_notice_off = {16'd0, val[15:0]};
      REG_NOTICE_REP: r_notice_rep = {24'd0, val[7:0]};
      REG_WORK_STEP:  r_work_step  = {16'd0, val[15:0]};
      REG_LIFETIME:   r_lifetime   = {16'd0, val[15:0]};
      default:        r_idle_sleep = val;
    endcase
  endtask

  // short timings so the patterns move within a few ticks
  task automatic fast_timings(int hi);
    write_reg(REG_FLASH_ON,   $urandom_range(1, hi));
    write_reg(REG_FLASH_OFF,  $urandom_range(1, hi));
    write_reg(REG_NOTICE_ON,  $urandom_range(1, hi));
    write_reg(REG_NOTICE_OFF, $urandom_range(1, hi));
    write_reg(REG_NOTICE_REP, $urandom_range(1, 4));
    write_reg(REG_WORK_STEP,  $urandom_range(1, hi));
    write_reg(REG_LIFETIME,   $urandom_range(1, 3));
    write_reg(REG_IDLE_SLEEP, $urandom_range(0, 40));
  endtask

  task automatic ticks(int n);
    repeat (n) send_item(REQ_TICK, $urandom, 4'($urandom_range(0, 15)));
  endtask

  // ---------------------------------------------------------------------
  // receiver: random stall, long hold-off on request, result check
  // ---------------------------------------------------------------------
  task automatic report_bad(string what, int got, int want);
    err_cnt++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  int hold_left = 0;
  always @(posedge clk) begin
    lamp_view_t want;
    if (out_valid && !out_stall) begin
      if (lamp_expect_q.size() == 0) begin
        report_bad("unexpected item", 1, 0);
      end else begin
        want = lamp_expect_q.pop_front();
        if (red_o !== want.red) report_bad("red_lamp", red_o, want.red);
        if (yel_o !== want.yel) report_bad("yellow_lamp", yel_o, want.yel);
        if (grn_o !== want.grn) report_bad("green_lamp", grn_o, want.grn);
        if (pat_o !== want.pat) report_bad("shown_pattern", pat_o, want.pat);
        if (lvl_o !== want.lvl) report_bad("combined_status", lvl_o, want.lvl);
        if (evt_o !== want.evt) report_bad("event_status", evt_o, want.evt);
        if (cnt_o !== want.cnt) report_bad("live_sessions", cnt_o, want.cnt);
      end
    end
    if (hold_req && hold_left == 0) hold_left = HOLD_LEN;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idling_on && ($urandom_range(99) < 30);
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------
  logic [31:0] key_pool[12];

  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 8) return $urandom;
    if (r < 12) return 32'd0;
    return key_pool[$urandom_range(0, 11)];
  endfunction

  function automatic logic [3:0] pick_code();
    if ($urandom_range(99) < 8) return 4'($urandom_range(13, 15));
    return 4'($urandom_range(0, 12));
  endfunction

  // every code up to 12, key extremes, unknown codes, reserved type, reset item
  task automatic test_directed_codes();
    send_item(REQ_TICK, 32'hFFFF_FFFF, 4'hF);
    for (int c = 0; c <= 12; c++) begin
      send_item(REQ_EVENT, (c % 2) ? 32'hFFFF_FFFF : 32'd0, 4'(c));
    end
    send_item(REQ_EVENT, 32'h1, 4'd13);
    send_item(REQ_EVENT, 32'h2, 4'd15);
    send_item(REQ_RSVD, 32'h3, SIG_BLOCKED);
    send_item(REQ_EVENT, 32'h5, SIG_BLOCKED);
    send_item(REQ_EVENT, 32'h5, SIG_TURN_END);   // turn end kept while blocked
    send_item(REQ_CLEAR, 32'h0, 4'd0);
    send_item(REQ_TICK, 32'h0, 4'd0);
    wait_drained();
  endtask

  // full table eviction with tied stamps and swap-in removal
  task automatic test_table_full();
    fast_timings(4);
    for (int i = 0; i < 10; i++) begin
      send_item(REQ_EVENT, key_pool[i], SIG_THINKING);
      if (i % 3 == 0) ticks(1);
    end
    send_item(REQ_EVENT, key_pool[2], SIG_SESS_END);
    send_item(REQ_EVENT, key_pool[9], SIG_TURN_END);
    send_item(REQ_EVENT, key_pool[4], SIG_OFF);
    ticks(20);
    wait_drained();
  endtask

  // extremes of every register but the lifetime (maximum only), zero timings and zero repeats included
  task automatic test_register_extremes();
    write_reg(REG_FLASH_ON, 32'd0);
    write_reg(REG_FLASH_OFF, 32'd0);
    write_reg(REG_NOTICE_ON, 32'd0);
    write_reg(REG_NOTICE_OFF, 32'd0);
    write_reg(REG_NOTICE_REP, 32'd0);
    write_reg(REG_WORK_STEP, 32'd0);
    write_reg(REG_IDLE_SLEEP, 32'd0);
    send_item(REQ_EVENT, 32'h10, SIG_ATTENTION);
    ticks(4);
    send_item(REQ_EVENT, 32'h10, SIG_SESS_DONE);
    ticks(6);
    wait_drained();
    write_reg(REG_FLASH_ON, 32'hFFFF);
    write_reg(REG_FLASH_OFF, 32'hFFFF);
    write_reg(REG_NOTICE_ON, 32'hFFFF);
    write_reg(REG_NOTICE_OFF, 32'hFFFF);
    write_reg(REG_NOTICE_REP, 32'hFF);
    write_reg(REG_WORK_STEP, 32'hFFFF);
    write_reg(REG_LIFETIME, 32'hFFFF);
    write_reg(REG_IDLE_SLEEP, 32'hFFFF_FFFF);
    send_item(REQ_EVENT, 32'h11, SIG_PERMISSION);
    ticks(3);
    send_item(REQ_EVENT, 32'h11, SIG_TURN_END);
    send_item(REQ_EVENT, 32'h11, SIG_SESS_END);
    ticks(3);
    wait_drained();
  endtask

  // long flat-out run of ticks with a short lifetime and a late event
  task automatic test_tick_run();
    fast_timings(6);
    write_reg(REG_LIFETIME, 32'd1);
    idling_on = 1'b0;
    for (int i = 0; i < 5; i++) send_item(REQ_EVENT, key_pool[i], 4'(i + 2));
    for (int i = 0; i < 250; i++) begin
      if (i == 200) send_item(REQ_EVENT, key_pool[7], SIG_BLOCKED);
      else send_item(REQ_TICK, 32'd0, 4'd0);
    end
    idling_on = 1'b1;
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) begin
      if (i == 1) hold_req = 1'b0;
      if (i % 2) send_item(REQ_TICK, 32'd0, 4'd0);
      else send_item(REQ_EVENT, pick_key(), pick_code());
    end
    wait_drained();
  endtask

  // random phases, each with its own register setting
  task automatic test_random_phases();
    for (int ph = 0; ph < 6; ph++) begin
      fast_timings(ph == 2 ? 2 : 12);
      idling_on = (ph != 3);   // one phase runs flat out
      for (int n = 0; n < 200; n++) begin
        int r;
        r = $urandom_range(99);
        if (r < 48) send_item(REQ_TICK, $urandom, 4'($urandom));
        else if (r < 95) send_item(REQ_EVENT, pick_key(), pick_code());
        else if (r < 98) send_item(REQ_CLEAR, $urandom, 4'($urandom));
        else send_item(REQ_RSVD, $urandom, 4'($urandom));
      end
      idling_on = 1'b1;
      wait_drained();
    end
  endtask

  initial begin
    for (int i = 0; i < 12; i++) key_pool[i] = $urandom;
    predictor_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_directed_codes();
    test_table_full();
    test_register_extremes();
    test_backpressure();
    test_random_phases();
    test_tick_run();
    wait_drained();
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
design/sslc_pkg.sv
design/sslc_table_ram.sv
design/session_status_light_controller_unit.sv
test/tb.sv
